FILE: rtl/bmp24_pkg.sv
// shared types and constants for the 24-bit bmp to rgb555 stream decoder
// no dependencies; imported by bmp24_to_rgb555_stream_decoder
package bmp24_pkg;

    // header byte positions and pixel data start floor
    localparam logic [15:0] HDR_OFFSET_POS = 16'd10;
    localparam logic [15:0] HDR_WIDTH_POS  = 16'd18;
    localparam logic [15:0] HDR_HEIGHT_POS = 16'd22;
    localparam logic [15:0] HDR_END        = 16'd24;
    localparam int          CHANNEL_SHIFT  = 3;
    localparam int          COORD_BITS_DEF = 12;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_ORIGIN_X     = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y     = 2'd1;
    localparam logic [1:0] CFG_COLUMN_LIMIT = 2'd2;

    localparam logic [15:0] COLUMN_LIMIT_RST = 16'hFFFF;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       file_start;
    } t_in_req;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [14:0] pixel_color;
        logic        last_pixel;
    } t_out_req;

endpackage

FILE: rtl/bmp24_to_rgb555_stream_decoder.sv
// top level of the 24-bit bmp to rgb555 stream decoder
// depends on bmp24_pkg for the request types, header positions and register indexes

// Takes a 24-bit BMP file one byte per request in file order and returns one
// RGB555 pixel request per blue/green/red triple of pixel data. A byte with
// file_start set restarts parsing at byte 0. Width, height and pixel data
// offset are captured from the header; pixel data begins at the larger of the
// offset and byte 24, rows carry no padding, and the bottom row comes first in
// the file so rows are flipped before origin_y is added. Coordinates wrap at
// COORD_BITS bits (and at the 12-bit port width). Pixels whose file column is
// at or beyond column_limit are counted but not sent. A zero width or height
// gives no pixels; bytes after the last pixel are ignored until the next file.
// Rate: one byte per clock unless the output stalls. Each byte is decoded by
// a single layer of counters, compares and adds straight into the output
// register, so the input is taken in every cycle in which the output register
// is empty or is being drained; a stalled output holds the input while it
// stays stalled. Configuration (origin_x, origin_y, column_limit) is always
// ready; the user must write it only while the stream is idle (unenforced).
module bmp24_to_rgb555_stream_decoder #(
    parameter int COORD_BITS = bmp24_pkg::COORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bmp24_pkg::t_in_req i_in_req,
    // pixel output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bmp24_pkg::t_out_req o_out_req,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import bmp24_pkg::*;

    // coordinate wrap mask, clipped to the 12-bit port fields
    localparam int          MaskBits  = (COORD_BITS < 12) ? COORD_BITS : 12;
    localparam logic [11:0] CoordMask = 12'((64'd1 << MaskBits) - 64'd1);

    // configuration registers
    logic [10:0] r_origin_x;
    logic [10:0] r_origin_y;
    logic [15:0] r_column_limit;

    // parse state
    logic [15:0] r_byte_index, n_byte_index;
    logic [15:0] r_data_offset, n_data_offset;
    logic [15:0] r_image_width, n_image_width;
    logic [15:0] r_image_height, n_image_height;
    logic [15:0] r_column_count, n_column_count;
    logic [15:0] r_row_count, n_row_count;
    logic [1:0]  r_triple_phase, n_triple_phase;
    logic [4:0]  r_held_blue, n_held_blue;
    logic [4:0]  r_held_green, n_held_green;
    logic        r_image_done, n_image_done;

    // output register
    logic     r_out_valid, n_out_valid;
    t_out_req r_out_req, n_out_req;

    // view of the state as this byte sees it (file_start restarts the file)
    logic [15:0] e_idx, e_off, e_width, e_height, e_col, e_row;
    logic [1:0]  e_phase;
    logic [4:0]  e_blue, e_green;
    logic        e_done;

    logic        in_accept;
    logic [15:0] pix_start;
    logic        pix_byte;
    logic        last_col, last_row;
    logic [15:0] flip_row;
    logic [4:0]  chan;

    assign o_cfg_ready = 1'b1;

    // take a byte whenever the result slot is free or leaving this cycle
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    always_comb begin
        if (i_in_req.file_start) begin
            e_idx    = '0;
            e_off    = '0;
            e_width  = '0;
            e_height = '0;
            e_col    = '0;
            e_row    = '0;
            e_phase  = '0;
            e_blue   = '0;
            e_green  = '0;
            e_done   = 1'b0;
        end else begin
            e_idx    = r_byte_index;
            e_off    = r_data_offset;
            e_width  = r_image_width;
            e_height = r_image_height;
            e_col    = r_column_count;
            e_row    = r_row_count;
            e_phase  = r_triple_phase;
            e_blue   = r_held_blue;
            e_green  = r_held_green;
            e_done   = r_image_done;
        end
    end

    // header fields only land below byte 24, so pixel checks can use the
    // values as they stood before this byte
    assign pix_start = (e_off > HDR_END) ? e_off : HDR_END;
    assign pix_byte  = (e_idx >= pix_start) && !e_done
                       && (e_width != '0) && (e_height != '0);
    assign last_col  = (e_col == e_width - 16'd1);
    assign last_row  = (e_row == e_height - 16'd1);
    assign flip_row  = e_height - 16'd1 - e_row;
    assign chan      = i_in_req.byte_value[7:CHANNEL_SHIFT];

    always_comb begin
        n_byte_index   = r_byte_index;
        n_data_offset  = r_data_offset;
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        n_column_count = r_column_count;
        n_row_count    = r_row_count;
        n_triple_phase = r_triple_phase;
        n_held_blue    = r_held_blue;
        n_held_green   = r_held_green;
        n_image_done   = r_image_done;
        n_out_valid    = r_out_valid & i_out_stall;
        n_out_req      = r_out_req;

        if (in_accept) begin
            n_data_offset  = e_off;
            n_image_width  = e_width;
            n_image_height = e_height;
            n_column_count = e_col;
            n_row_count    = e_row;
            n_triple_phase = e_phase;
            n_held_blue    = e_blue;
            n_held_green   = e_green;
            n_image_done   = e_done;
            n_out_valid    = 1'b0;

            // little-endian header capture
            if (e_idx == HDR_OFFSET_POS) begin
                n_data_offset = {e_off[15:8], i_in_req.byte_value};
            end else if (e_idx == HDR_OFFSET_POS + 16'd1) begin
                n_data_offset = {i_in_req.byte_value, e_off[7:0]};
            end else if (e_idx == HDR_WIDTH_POS) begin
                n_image_width = {e_width[15:8], i_in_req.byte_value};
            end else if (e_idx == HDR_WIDTH_POS + 16'd1) begin
                n_image_width = {i_in_req.byte_value, e_width[7:0]};
            end else if (e_idx == HDR_HEIGHT_POS) begin
                n_image_height = {e_height[15:8], i_in_req.byte_value};
            end else if (e_idx == HDR_HEIGHT_POS + 16'd1) begin
                n_image_height = {i_in_req.byte_value, e_height[7:0]};
            end

            if (pix_byte) begin
                case (e_phase)
                    2'd0: begin
                        n_held_blue    = chan;
                        n_triple_phase = 2'd1;
                    end
                    2'd1: begin
                        n_held_green   = chan;
                        n_triple_phase = 2'd2;
                    end
                    default: begin
                        n_triple_phase = 2'd0;
                        if (e_col < r_column_limit) begin
                            n_out_valid           = 1'b1;
                            n_out_req.pixel_x     = ({1'b0, r_origin_x} + e_col[11:0])
                                                    & CoordMask;
                            n_out_req.pixel_y     = ({1'b0, r_origin_y} + flip_row[11:0])
                                                    & CoordMask;
                            n_out_req.pixel_color = {chan, e_green, e_blue};
                            n_out_req.last_pixel  = last_col & last_row;
                        end
                        if (last_col) begin
                            n_column_count = '0;
                            if (last_row) begin
                                n_image_done = 1'b1;
                            end else begin
                                n_row_count = e_row + 16'd1;
                            end
                        end else begin
                            n_column_count = e_col + 16'd1;
                        end
                    end
                endcase
            end

            // byte counter saturates on long files
            if (e_idx != 16'hFFFF) begin
                n_byte_index = e_idx + 16'd1;
            end else begin
                n_byte_index = e_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_column_limit <= COLUMN_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:     r_origin_x     <= i_cfg_data[10:0];
                CFG_ORIGIN_Y:     r_origin_y     <= i_cfg_data[10:0];
                CFG_COLUMN_LIMIT: r_column_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_data_offset  <= '0;
            r_image_width  <= '0;
            r_image_height <= '0;
            r_column_count <= '0;
            r_row_count    <= '0;
            r_triple_phase <= '0;
            r_held_blue    <= '0;
            r_held_green   <= '0;
            r_image_done   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_byte_index   <= n_byte_index;
            r_data_offset  <= n_data_offset;
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_column_count <= n_column_count;
            r_row_count    <= n_row_count;
            r_triple_phase <= n_triple_phase;
            r_held_blue    <= n_held_blue;
            r_held_green   <= n_held_green;
            r_image_done   <= n_image_done;
            r_out_valid    <= n_out_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_req <= n_out_req;
    end

`ifndef SYNTHESIS
    // the phase counter only walks blue, green, red
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_triple_phase != 2'd3)
        else $error("triple phase out of range");

    // a waiting final pixel means the image has been closed
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_req.last_pixel) |-> r_image_done)
        else $error("last pixel sent without image done");

    // the column position never runs past the captured width
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_image_width != '0 && r_column_count != '0)
            |-> (r_column_count < r_image_width))
        else $error("column count beyond image width");

    // a pixel is only produced by an accepted byte
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_accept && !(r_out_valid && i_out_stall)) |=> !o_out_valid)
        else $error("pixel appeared without an accepted byte");
`endif

endmodule
